// ===== rtl/jdc_pkg.sv =====
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared types, constants and small calendar tables for the Julian day
// number converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

   localparam int unsigned PIPE_DEPTH = 7;

   localparam logic [22:0] JDN_MIN  = 23'd1721060;
   localparam logic [22:0] JDN_MAX  = 23'd5373484;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic {
      OP_TO_JDN  = 1'b0,
      OP_TO_DATE = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [22:0] jdn;
   } item_type;

   typedef struct packed {
      logic [22:0] jdn;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      status_type  status;
   } result_type;

   // days in a common year, zero for codes that are no month
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      len = 5'd0;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   // floor(367 * mm / 12) for the march-based month index
   function automatic logic [8:0] month_offset(input logic [3:0] mm);
      logic [8:0] ofs;
      ofs = 9'd0;
      case (mm)
         4'd1:    ofs = 9'd30;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd91;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd152;
         4'd6:    ofs = 9'd183;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd244;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd305;
         4'd11:   ofs = 9'd336;
         4'd12:   ofs = 9'd367;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

// ===== rtl/jdc_cdiv.sv =====
// ----------------------------------------------------------------------------
// jdc_cdiv
// Division of an unsigned value by a constant through a rounded-up
// reciprocal; exact for every dividend below 2**XW.
// ----------------------------------------------------------------------------
module jdc_cdiv #(
   parameter int unsigned D  = 7,
   parameter int unsigned XW = 8,
   parameter int unsigned QW = 8
) (
   input  logic [XW-1:0] dividend,
   output logic [QW-1:0] quotient
);

   localparam int unsigned SH = XW + $clog2(D);
   localparam int unsigned RW = XW + 2;
   localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
   localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

   logic [XW+RW-1:0] prod;

   assign prod     = (XW+RW)'(dividend) * (XW+RW)'(RECIP);
   assign quotient = QW'(prod >> SH);

endmodule

// ===== rtl/jdc_to_jdn.sv =====
// ----------------------------------------------------------------------------
// jdc_to_jdn
// Date check and year/month/day to Julian day number, with weekday.
// ----------------------------------------------------------------------------
module jdc_to_jdn (
   input  logic               clock,
   input  logic               en,
   input  jdc_pkg::item_type   item,
   output jdc_pkg::result_type result
);
   import jdc_pkg::*;

   localparam int unsigned DLY = PIPE_DEPTH - 3;

   // stage 1
   logic        a_in;
   logic [14:0] ya_in;
   logic [14:0] cx_in;
   logic [3:0]  mm_in;
   logic [7:0]  yq_in;
   logic [7:0]  cq_in;
   logic [24:0] t1_in;
   logic        mok_in;

   logic [13:0] s1_year_ff;
   logic [6:0]  s1_month_ff;
   logic [6:0]  s1_day_ff;
   logic [3:0]  s1_mm_ff;
   logic [7:0]  s1_yq_ff;
   logic [7:0]  s1_cq_ff;
   logic [24:0] s1_t1_ff;
   logic        s1_mok_ff;

   // stage 2
   logic        leap_in;
   logic [4:0]  len_in;
   logic        ok_in;
   logic [9:0]  cent_in;
   logic [24:0] jsum_in;
   result_type  s2_in;
   result_type  s2_ff;

   // stage 3
   logic [20:0] q7_in;
   result_type  s3_ff;
   logic [20:0] s3_q7_ff;

   // stage 4 on
   result_type  s4_in;
   result_type  dly_ff [DLY];

   assign a_in   = (item.month <= 7'd2);
   assign ya_in  = 15'(item.year) + 15'd4800 - 15'(a_in);
   assign cx_in  = ya_in + 15'd100;
   assign mm_in  = a_in ? 4'(item.month[3:0] + 4'd10) : 4'(item.month[3:0] - 4'd2);
   assign t1_in  = 25'(ya_in) * 25'd1461;
   assign mok_in = (item.month inside {[7'd1:7'd12]});

   jdc_cdiv #(.D(100), .XW(14), .QW(8)) u_year_div (
      .dividend (item.year),
      .quotient (yq_in)
   );

   jdc_cdiv #(.D(100), .XW(15), .QW(8)) u_cent_div (
      .dividend (cx_in),
      .quotient (cq_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s1_year_ff  <= item.year;
         s1_month_ff <= item.month;
         s1_day_ff   <= item.day;
         s1_mm_ff    <= mm_in;
         s1_yq_ff    <= yq_in;
         s1_cq_ff    <= cq_in;
         s1_t1_ff    <= t1_in;
         s1_mok_ff   <= mok_in;
      end
   end

   // leap by 4/100/400: divisible by 100 when year == 100 * (year / 100)
   always_comb begin
      leap_in = (s1_year_ff[1:0] == 2'd0) &&
                ((s1_year_ff != 14'(14'(s1_yq_ff) * 14'd100)) || (s1_yq_ff[1:0] == 2'd0));
      len_in  = month_len(s1_month_ff[3:0]) + 5'((s1_month_ff == 7'd2) && leap_in);
      ok_in   = s1_mok_ff && (s1_day_ff != 7'd0) && (s1_day_ff <= 7'(len_in));
      cent_in = 10'((10'(s1_cq_ff) * 10'd3) >> 2);
      jsum_in = 25'(s1_t1_ff >> 2) + 25'(month_offset(s1_mm_ff)) + 25'(s1_day_ff)
              - 25'(cent_in) - 25'd32075;

      s2_in         = '0;
      s2_in.year    = s1_year_ff;
      if (!ok_in) begin
         s2_in.status = ST_INVALID;
      end else if (s1_year_ff > YEAR_MAX) begin
         s2_in.status = ST_RANGE;
      end else begin
         s2_in.status = ST_OK;
         s2_in.jdn    = jsum_in[22:0];
         s2_in.month  = s1_month_ff[3:0];
         s2_in.day    = s1_day_ff[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
      end
   end

   jdc_cdiv #(.D(7), .XW(23), .QW(21)) u_wday_div (
      .dividend (s2_ff.jdn),
      .quotient (q7_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff    <= s2_ff;
         s3_q7_ff <= q7_in;
      end
   end

   always_comb begin
      s4_in         = s3_ff;
      s4_in.weekday = 3'(s3_ff.jdn - 23'(23'(s3_q7_ff) * 23'd7));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= s4_in;
         for (int i = 1; i < DLY; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign result = dly_ff[DLY-1];

endmodule

// ===== rtl/jdc_to_date.sv =====
// ----------------------------------------------------------------------------
// jdc_to_date
// Julian day number to year/month/day by Richards' algorithm, with range
// check and weekday.
// ----------------------------------------------------------------------------
module jdc_to_date (
   input  logic               clock,
   input  logic               en,
   input  jdc_pkg::item_type   item,
   output jdc_pkg::result_type result
);
   import jdc_pkg::*;

   // stage 1
   logic [24:0] tx_in;
   logic [7:0]  t_in;
   logic        jok_in;
   logic [22:0] s1_j_ff;
   logic [13:0] s1_year_ff;
   logic [7:0]  s1_t_ff;
   logic        s1_jok_ff;

   // stage 2
   logic [23:0] f_in;
   logic [20:0] q7_in;
   logic [22:0] s2_j_ff;
   logic [13:0] s2_year_ff;
   logic        s2_jok_ff;
   logic [25:0] s2_e_ff;
   logic [20:0] s2_q7_ff;

   // stage 3
   logic [15:0] qe_in;
   logic [22:0] s3_j_ff;
   logic [13:0] s3_year_ff;
   logic        s3_jok_ff;
   logic [25:0] s3_e_ff;
   logic [15:0] s3_qe_ff;
   logic [2:0]  s3_wd_ff;

   // stage 4
   logic [10:0] rem_in;
   logic [10:0] h_in;
   logic [22:0] s4_j_ff;
   logic [13:0] s4_year_ff;
   logic        s4_jok_ff;
   logic [15:0] s4_qe_ff;
   logic [2:0]  s4_wd_ff;
   logic [10:0] s4_h_ff;

   // stage 5
   logic [3:0]  hq_in;
   logic [22:0] s5_j_ff;
   logic [13:0] s5_year_ff;
   logic        s5_jok_ff;
   logic [15:0] s5_qe_ff;
   logic [2:0]  s5_wd_ff;
   logic [10:0] s5_h_ff;
   logic [3:0]  s5_hq_ff;

   // stage 6
   logic [7:0]  hr_in;
   logic [3:0]  mt_in;
   logic [3:0]  mo_in;
   logic [13:0] yo_in;
   logic [22:0] s6_j_ff;
   logic [13:0] s6_year_ff;
   logic        s6_jok_ff;
   logic [2:0]  s6_wd_ff;
   logic [7:0]  s6_hr_ff;
   logic [3:0]  s6_mo_ff;
   logic [13:0] s6_yo_ff;

   // stage 7
   logic [4:0]  dq_in;
   result_type  s7_in;
   result_type  s7_ff;

   // out-of-range numbers may wrap here; their date fields are dropped later
   assign tx_in  = {item.jdn, 2'b00} + 25'd274277;
   assign jok_in = (item.jdn inside {[JDN_MIN:JDN_MAX]});

   jdc_cdiv #(.D(146097), .XW(25), .QW(8)) u_era_div (
      .dividend (tx_in),
      .quotient (t_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s1_j_ff    <= item.jdn;
         s1_year_ff <= item.year;
         s1_t_ff    <= t_in;
         s1_jok_ff  <= jok_in;
      end
   end

   assign f_in = 24'(s1_j_ff) + 24'd1401 + 24'((10'(s1_t_ff) * 10'd3) >> 2) - 24'd38;

   jdc_cdiv #(.D(7), .XW(23), .QW(21)) u_wday_div (
      .dividend (s1_j_ff),
      .quotient (q7_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s2_j_ff    <= s1_j_ff;
         s2_year_ff <= s1_year_ff;
         s2_jok_ff  <= s1_jok_ff;
         s2_e_ff    <= {f_in, 2'b11};
         s2_q7_ff   <= q7_in;
      end
   end

   jdc_cdiv #(.D(1461), .XW(26), .QW(16)) u_cycle_div (
      .dividend (s2_e_ff),
      .quotient (qe_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s3_j_ff    <= s2_j_ff;
         s3_year_ff <= s2_year_ff;
         s3_jok_ff  <= s2_jok_ff;
         s3_e_ff    <= s2_e_ff;
         s3_qe_ff   <= qe_in;
         s3_wd_ff   <= 3'(s2_j_ff - 23'(23'(s2_q7_ff) * 23'd7));
      end
   end

   // day within the four-year cycle, then the 153-day month grouping
   assign rem_in = 11'(s3_e_ff - 26'(26'(s3_qe_ff) * 26'd1461));
   assign h_in   = 11'(11'(rem_in[10:2]) * 11'd5 + 11'd2);

   always_ff @(posedge clock) begin
      if (en) begin
         s4_j_ff    <= s3_j_ff;
         s4_year_ff <= s3_year_ff;
         s4_jok_ff  <= s3_jok_ff;
         s4_qe_ff   <= s3_qe_ff;
         s4_wd_ff   <= s3_wd_ff;
         s4_h_ff    <= h_in;
      end
   end

   jdc_cdiv #(.D(153), .XW(11), .QW(4)) u_month_div (
      .dividend (s4_h_ff),
      .quotient (hq_in)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s5_j_ff    <= s4_j_ff;
         s5_year_ff <= s4_year_ff;
         s5_jok_ff  <= s4_jok_ff;
         s5_qe_ff   <= s4_qe_ff;
         s5_wd_ff   <= s4_wd_ff;
         s5_h_ff    <= s4_h_ff;
         s5_hq_ff   <= hq_in;
      end
   end

   always_comb begin
      hr_in = 8'(s5_h_ff - 11'(11'(s5_hq_ff) * 11'd153));
      mt_in = s5_hq_ff + 4'd2;
      mo_in = (mt_in >= 4'd12) ? 4'(mt_in - 4'd11) : 4'(mt_in + 4'd1);
      // january and february count to the following year
      yo_in = 14'(s5_qe_ff - 16'd4716 + 16'(mo_in <= 4'd2));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_j_ff    <= s5_j_ff;
         s6_year_ff <= s5_year_ff;
         s6_jok_ff  <= s5_jok_ff;
         s6_wd_ff   <= s5_wd_ff;
         s6_hr_ff   <= hr_in;
         s6_mo_ff   <= mo_in;
         s6_yo_ff   <= yo_in;
      end
   end

   jdc_cdiv #(.D(5), .XW(8), .QW(5)) u_day_div (
      .dividend (s6_hr_ff),
      .quotient (dq_in)
   );

   always_comb begin
      s7_in         = '0;
      s7_in.jdn     = s6_j_ff;
      s7_in.weekday = s6_wd_ff;
      if (s6_jok_ff) begin
         s7_in.status = ST_OK;
         s7_in.year   = s6_yo_ff;
         s7_in.month  = s6_mo_ff;
         s7_in.day    = dq_in + 5'd1;
      end else begin
         s7_in.status = ST_RANGE;
         s7_in.year   = s6_year_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ff <= s7_in;
      end
   end

   assign result = s7_ff;

endmodule

// ===== rtl/julian_day_converter_core.sv =====
// ----------------------------------------------------------------------------
// julian_day_converter_core
// Gregorian date <-> Julian day number converter with date check and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_*) carries one conversion per transfer: tuser is
//   the opcode (0 date to day number, 1 day number to date), tdata the year,
//   month, day and day number. The response channel (rsp_*) returns exactly
//   one result per request, in order, with the status code on tuser.
//   A request passes seven pipeline stages of constant-divisor arithmetic (the
//   shorter date-to-day-number path is padded with plain delay stages) and
//   the output register. Throughput is one transfer per cycle unless the output
//   stalls; both opcodes run down parallel paths of equal depth and a new
//   request may enter every cycle that req_tready is high. When the receiver
//   holds rsp_tready low with a result waiting, the whole pipeline freezes
//   and req_tready drops in the same cycle; nothing is dropped or repeated.
//   Empty stages ahead of the output still fill while rsp_tvalid is low. Reset
//   clears the stage valid bits, so the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module julian_day_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // year_in[13:0], month_in[20:14], day_in[27:21],
                                   // jdn_in[50:28], zero[55:51]
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // jdn_out[22:0], year_out[36:23], month_out[40:37],
                                   // day_out[45:41], weekday[48:46], zero[55:49]
   output logic [1:0]  rsp_tuser   // status
);
   import jdc_pkg::*;

   logic                  adv;
   item_type              req_item;
   result_type            jdn_res;
   result_type            date_res;
   result_type            rsp_res_in;
   result_type            rsp_res_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] op_ff;
   logic                  rsp_vld_ff;

   // whole pipeline moves together unless a result is stuck at the output
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   assign req_item.opcode = opcode_type'(req_tuser);
   assign req_item.year   = req_tdata[13:0];
   assign req_item.month  = req_tdata[20:14];
   assign req_item.day    = req_tdata[27:21];
   assign req_item.jdn    = req_tdata[50:28];

   jdc_to_jdn u_to_jdn (
      .clock  (clock),
      .en     (adv),
      .item   (req_item),
      .result (jdn_res)
   );

   jdc_to_date u_to_date (
      .clock  (clock),
      .en     (adv),
      .item   (req_item),
      .result (date_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
         rsp_vld_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff <= {op_ff[PIPE_DEPTH-2:0], req_tuser};
      end
   end

   assign rsp_res_in = (opcode_type'(op_ff[PIPE_DEPTH-1]) == OP_TO_DATE) ? date_res : jdn_res;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, rsp_res_ff.weekday, rsp_res_ff.day, rsp_res_ff.month,
                        rsp_res_ff.year, rsp_res_ff.jdn};
   assign rsp_tuser  = rsp_res_ff.status;

   // a good result always carries a real calendar date
   a_ok_has_date: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_res_ff.status == ST_OK) |->
         (rsp_res_ff.month >= 4'd1) && (rsp_res_ff.month <= 4'd12) &&
         (rsp_res_ff.day >= 5'd1))
      else $error("ok result without a valid month and day");

   a_err_no_date: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_res_ff.status != ST_OK) |->
         (rsp_res_ff.month == 4'd0) && (rsp_res_ff.day == 5'd0))
      else $error("failed result carries month or day");

   a_invalid_no_jdn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_res_ff.status == ST_INVALID) |->
         (rsp_res_ff.jdn == 23'd0) && (rsp_res_ff.weekday == 3'd0))
      else $error("invalid date result carries a day number");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_res_ff.weekday <= 3'd6))
      else $error("weekday out of range");

endmodule

// ===== tb/tb_julian_day_converter_core.sv =====
// ----------------------------------------------------------------------------
// tb_julian_day_converter_core
// Checks both conversions of the calendar core (date to day number, day number
// to date) against a behavioral calendar model: directed edge dates first,
// then a random mix of valid dates, month-end boundaries, out-of-range years
// and day numbers, and raw noise. Both stream sides idle at random, then run flat out.
// ----------------------------------------------------------------------------
module tb_julian_day_converter_core;
   import jdc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   item_type    req_item = '0;
   logic        req_taken = 1'b0;

   item_type    request_backlog[$];
   result_type  conversions_due[$];
   int unsigned request_total = 0;
   int unsigned req_transfers = 0;
   int unsigned field_errors = 0;

   // tdata: year, month, day, day number from the lowest bit up
   assign req_tdata = {5'b0, req_item.jdn, req_item.day, req_item.month, req_item.year};
   assign req_tuser = req_item.opcode;

   julian_day_converter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic int days_in_month(input int year, input int month);
      bit leap;
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic result_type calendar_convert(input item_type req);
      result_type res;
      longint     len, a, ya, mm, j, f, e, g, h, m;
      res.jdn     = '0;
      res.year    = req.year;
      res.month   = '0;
      res.day     = '0;
      res.weekday = '0;
      res.status  = ST_OK;
      if (req.opcode == OP_TO_JDN) begin
         len = days_in_month(req.year, req.month);
         // date check wins over the year range check
         if (len == 0 || req.day < 1 || req.day > len) begin
            res.status = ST_INVALID;
         end else if (req.year > YEAR_MAX) begin
            res.status = ST_RANGE;
         end else begin
            a  = (req.month <= 2) ? 1 : 0;
            ya = req.year + 4800 - a;
            mm = req.month + 12 * a - 2;
            j  = (1461 * ya) / 4 + (367 * mm) / 12 - (3 * ((ya + 100) / 100)) / 4
                 + req.day - 32075;
            res.jdn     = j[22:0];
            res.month   = req.month[3:0];
            res.day     = req.day[4:0];
            res.weekday = 3'(j % 7);
         end
      end else begin
         j           = req.jdn;
         res.jdn     = req.jdn;
         res.weekday = 3'(j % 7);
         if (req.jdn < JDN_MIN || req.jdn > JDN_MAX) begin
            res.status = ST_RANGE;
         end else begin
            f = j + 1401 + (((4 * j + 274277) / 146097) * 3) / 4 - 38;
            e = 4 * f + 3;
            g = (e % 1461) / 4;
            h = 5 * g + 2;
            m = (h / 153 + 2) % 12 + 1;
            res.day   = 5'((h % 153) / 5 + 1);
            res.month = 4'(m);
            res.year  = 14'(e / 1461 - 4716 + (14 - m) / 12);
         end
      end
      return res;
   endfunction

   task automatic queue_request(input opcode_type op, input int year, input int month,
                                input int day, input int jdn);
      item_type req;
      req.opcode = op;
      req.year   = year[13:0];
      req.month  = month[6:0];
      req.day    = day[6:0];
      req.jdn    = jdn[22:0];
      request_backlog.push_back(req);
   endtask

   task automatic compare_field(input string field, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s differs, expected %0d actual %0d", $time, field, want, got);
         field_errors++;
      end
   endtask

   // sender and receiver; idle rates move through three phases by transfer count
   always @(negedge clock) begin : drive
      int unsigned send_idle;
      int unsigned recv_idle;
      if (req_transfers < 600) begin
         send_idle = 22;
         recv_idle = 50;
      end else if (req_transfers < 1200) begin
         send_idle = 50;
         recv_idle = 22;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_item   <= request_backlog.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : observe
      result_type seen;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            conversions_due.push_back(calendar_convert(req_item));
            req_transfers++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.jdn     = rsp_tdata[22:0];
            seen.year    = rsp_tdata[36:23];
            seen.month   = rsp_tdata[40:37];
            seen.day     = rsp_tdata[45:41];
            seen.weekday = rsp_tdata[48:46];
            seen.status  = status_type'(rsp_tuser);
            if (conversions_due.size() == 0) begin
               $display("%0t: unrequested result, expected none actual jdn %0d status %0d",
                        $time, seen.jdn, seen.status);
               field_errors++;
            end else begin
               want = conversions_due.pop_front();
               compare_field("jdn", want.jdn, seen.jdn);
               compare_field("year", want.year, seen.year);
               compare_field("month", want.month, seen.month);
               compare_field("day", want.day, seen.day);
               compare_field("weekday", want.weekday, seen.weekday);
               compare_field("status", want.status, seen.status);
               compare_field("tdata pad", 0, rsp_tdata[55:49]);
            end
         end
      end
   end

   initial begin : run
      int pick, year, month, day, len;
      // date to day number: range ends, leap rules, bad months and days
      queue_request(OP_TO_JDN, 0, 1, 1, 0);
      queue_request(OP_TO_JDN, 0, 2, 29, 0);
      queue_request(OP_TO_JDN, 9999, 12, 31, 0);
      queue_request(OP_TO_JDN, 2000, 2, 29, 0);
      queue_request(OP_TO_JDN, 1900, 2, 29, 0);
      queue_request(OP_TO_JDN, 2024, 2, 29, 0);
      queue_request(OP_TO_JDN, 2023, 2, 29, 0);
      queue_request(OP_TO_JDN, 2023, 4, 30, 0);
      queue_request(OP_TO_JDN, 2023, 4, 31, 0);
      queue_request(OP_TO_JDN, 2023, 0, 10, 0);
      queue_request(OP_TO_JDN, 2023, 13, 1, 0);
      queue_request(OP_TO_JDN, 2023, 127, 127, 0);
      queue_request(OP_TO_JDN, 2023, 1, 0, 0);
      // year past the top with a good date is a range error, not invalid; with a bad date it is invalid
      queue_request(OP_TO_JDN, 10000, 1, 1, 0);
      queue_request(OP_TO_JDN, 10000, 2, 29, 0);
      queue_request(OP_TO_JDN, 16383, 12, 31, 0);
      queue_request(OP_TO_JDN, 16383, 2, 29, 0);
      // day number to date: range ends, just outside, both field extremes and one day inside
      queue_request(OP_TO_DATE, 0, 0, 0, JDN_MIN);
      queue_request(OP_TO_DATE, 0, 0, 0, JDN_MIN - 23'd1);
      queue_request(OP_TO_DATE, 0, 0, 0, JDN_MAX);
      queue_request(OP_TO_DATE, 16383, 127, 127, JDN_MAX + 23'd1);
      queue_request(OP_TO_DATE, 0, 0, 0, 0);
      queue_request(OP_TO_DATE, 0, 0, 0, 23'h7FFFFF);
      queue_request(OP_TO_DATE, 0, 0, 0, 2451545);
      repeat (1780) begin
         pick  = $urandom_range(0, 99);
         year  = $urandom_range(0, 16383);
         month = $urandom_range(0, 127);
         day   = $urandom_range(0, 127);
         if (pick < 40) begin
            year  = $urandom_range(0, 9999);
            month = $urandom_range(1, 12);
            day   = $urandom_range(1, days_in_month(year, month));
         end else if (pick < 46) begin
            month = $urandom_range(1, 12);
            day   = $urandom_range(1, days_in_month(year, month));
         end else if (pick < 56) begin
            // month ends and one past
            year  = $urandom_range(0, 9999);
            month = $urandom_range(0, 13);
            len   = days_in_month(year, month);
            day   = len + $urandom_range(0, 1);
         end
         if (pick < 62) begin
            queue_request(OP_TO_JDN, year, month, day, $urandom_range(0, 23'h7FFFFF));
         end else if (pick < 90) begin
            queue_request(OP_TO_DATE, year, month, day, $urandom_range(JDN_MIN, JDN_MAX));
         end else begin
            queue_request(OP_TO_DATE, year, month, day, $urandom_range(0, 23'h7FFFFF));
         end
      end
      request_total = request_backlog.size();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (req_transfers != request_total) @(posedge clock);
      while (conversions_due.size() != 0) @(posedge clock);
      repeat (3 * PIPE_DEPTH) @(posedge clock);
      if (field_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
